// File: sv/eased_interval_tween_core_assert.svh
// ----------------------------------------------------------------------------
// Eased interval tween assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EASED_INTERVAL_TWEEN_CORE_ASSERT_SVH
`define EASED_INTERVAL_TWEEN_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EIT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/eit_pkg.sv
// ----------------------------------------------------------------------------
// Eased interval tween package
// Fixed-point widths, codes and payload types shared by the tween modules.
// ----------------------------------------------------------------------------
package eit_pkg;

    // Fixed-point formats: values signed Q16.16, fraction Q1.16.
    localparam int FRAC_BITS = 16;
    localparam int VALUE_W   = 32;
    localparam int TIME_W    = 32;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int SHAPE_W   = T_W + 3;
    localparam logic [T_W-1:0] FRAC_ONE = T_W'(1) << FRAC_BITS;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = VALUE_W + 2;
    localparam int MUL_B_W = T_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_START_VALUE = 2'd0,
        REG_STOP_VALUE  = 2'd1,
        REG_DURATION    = 2'd2,
        REG_BLEND_MODE  = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_LINEAR    = 2'd0,
        MODE_EASE_IN   = 2'd1,
        MODE_EASE_OUT  = 2'd2,
        MODE_EASE_BOTH = 2'd3
    } blend_mode_t;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } command_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] start_value;
        logic signed [VALUE_W-1:0] stop_value;
        logic        [TIME_W-1:0]  duration;
        blend_mode_t               blend_mode;
    } cfg_t;

    typedef struct packed {
        command_t            command;
        logic [TIME_W-1:0]   delta_time;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] current_value;
        logic        [T_W-1:0]     blend_fraction;
        logic                      updated;
        logic                      finished;
        logic                      running;
    } rsp_t;

endpackage

// File: sv/eased_interval_tween_core.sv
// ----------------------------------------------------------------------------
// Eased interval tween core
// Time-driven tween: ticks advance elapsed time, a linear or cubic-eased fraction
// blends the output from start value to stop value.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  request  | req_valid, req_ready, req (req_t)         | in
//  response | rsp_valid, rsp_ready, rsp (rsp_t)         | out
//  config   | psel, penable, pwrite, paddr, pwdata,     | in/out
//           | prdata, pready                            |
//
//  A tick that needs a division is taken, has its elapsed time compared,
//  waits on the bit-serial divider, then steps through square, cube,
//  shape, blend and output before the next request is taken.
//  A tick whose fraction is already one skips the divider.
//  A start command or an idle tick goes straight to output.
//  Reset returns all state but the multiplier's product register to zero with the interval idle.
//  A waiting response does not block the next request; only the final
//  write of the response register waits for rsp_ready.
// ----------------------------------------------------------------------------
`include "eased_interval_tween_core_assert.svh"

module eased_interval_tween_core
    import eit_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAC,
        S_DIV,
        S_SQR,
        S_CUBE,
        S_SHAPE,
        S_BLEND,
        S_OUT
    } state_t;

    state_t                    state_reg;
    cfg_t                      cfg;
    logic [TIME_W-1:0]         elapsed_reg;
    logic signed [VALUE_W-1:0] level_reg;
    logic [T_W-1:0]            shaped_reg;
    logic                      active_reg;
    logic                      updated_reg;
    logic [T_W-1:0]            t_reg;
    logic [T_W-1:0]            t2_reg;
    logic                      rsp_valid_reg;
    rsp_t                      rsp_reg;

    logic                      accept;
    logic                      rsp_load;
    logic [TIME_W:0]           elapsed_sum;
    logic                      div_start;
    logic                      div_done;
    logic [FRAC_BITS-1:0]      div_quot;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [MUL_A_W-1:0] level_diff;
    logic [T_W-1:0]            mul_hi;
    logic [SHAPE_W-1:0]        three_t2;
    logic [SHAPE_W-1:0]        three_t;
    logic [SHAPE_W-1:0]        t3_ext;
    logic [SHAPE_W-1:0]        shape_raw;
    logic [T_W-1:0]            shape_clamp;

    // Configuration registers.
    eit_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Fraction divider, started once the elapsed time is below the duration.
    assign div_start = (state_reg == S_FRAC) && (cfg.duration != '0)
                       && (elapsed_reg < cfg.duration);

    eit_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_reg),
        .divisor  (cfg.duration),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Shared multiplier operand select: t*t, t2*t, then the blend step.
    assign level_diff = MUL_A_W'(cfg.stop_value) - MUL_A_W'(cfg.start_value);
    assign mul_hi     = mul_p[FRAC_BITS +: T_W];

    always_comb
    begin
        case (state_reg)
            S_SQR:
            begin
                mul_a = $signed({{(MUL_A_W-T_W){1'b0}}, t_reg});
                mul_b = t_reg;
            end
            S_CUBE:
            begin
                mul_a = $signed({{(MUL_A_W-T_W){1'b0}}, mul_hi});
                mul_b = t_reg;
            end
            default:
            begin
                mul_a = level_diff;
                mul_b = shaped_reg;
            end
        endcase
    end

    eit_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    // Ease curve from t, t2 and t3 (t3 is the current product), clamped to one.
    assign three_t2 = SHAPE_W'(3) * SHAPE_W'(t2_reg);
    assign three_t  = SHAPE_W'(3) * SHAPE_W'(t_reg);
    assign t3_ext   = SHAPE_W'(mul_hi);

    always_comb
    begin
        case (cfg.blend_mode)
            MODE_EASE_IN:   shape_raw = (three_t2 - t3_ext) >> 1;
            MODE_EASE_OUT:  shape_raw = (three_t - t3_ext) >> 1;
            MODE_EASE_BOTH: shape_raw = three_t2 - (t3_ext << 1);
            default:        shape_raw = SHAPE_W'(t_reg);
        endcase
    end

    assign shape_clamp = (shape_raw > SHAPE_W'(FRAC_ONE)) ? FRAC_ONE : shape_raw[T_W-1:0];

    // Saturating elapsed-time add.
    assign elapsed_sum = {1'b0, elapsed_reg} + {1'b0, req.delta_time};

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_load  = (state_reg == S_OUT) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer with the interval state and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            elapsed_reg   <= '0;
            level_reg     <= '0;
            shaped_reg    <= '0;
            active_reg    <= 1'b0;
            updated_reg   <= 1'b0;
            t_reg         <= '0;
            t2_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            // The response is valid from its load until it is taken.
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        updated_reg <= 1'b0;
                        if (req.command == CMD_START)
                        begin
                            elapsed_reg <= '0;
                            level_reg   <= cfg.start_value;
                            shaped_reg  <= '0;
                            active_reg  <= 1'b1;
                            state_reg   <= S_OUT;
                        end
                        else if (active_reg)
                        begin
                            elapsed_reg <= elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];
                            state_reg   <= S_FRAC;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_FRAC:
                begin
                    // Zero duration or time at or past the end gives a full fraction.
                    if (div_start)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        t_reg     <= FRAC_ONE;
                        state_reg <= S_SQR;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        t_reg     <= {1'b0, div_quot};
                        state_reg <= S_SQR;
                    end
                end
                S_SQR:
                begin
                    state_reg <= S_CUBE;
                end
                S_CUBE:
                begin
                    t2_reg    <= mul_hi;
                    state_reg <= S_SHAPE;
                end
                S_SHAPE:
                begin
                    shaped_reg <= shape_clamp;
                    state_reg  <= S_BLEND;
                end
                S_BLEND:
                begin
                    // The blend product is registered here and used in S_OUT.
                    state_reg <= S_OUT;
                    updated_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (rsp_load)
                    begin
                        state_reg <= S_IDLE;
                        if (updated_reg)
                        begin
                            // Blend step is floor(shaped * diff / one), added to start.
                            level_reg <= cfg.start_value + mul_p[FRAC_BITS +: VALUE_W];
                            rsp_reg.current_value <= cfg.start_value
                                                     + mul_p[FRAC_BITS +: VALUE_W];
                            if (t_reg[FRAC_BITS])
                            begin
                                active_reg       <= 1'b0;
                                rsp_reg.finished <= 1'b1;
                                rsp_reg.running  <= 1'b0;
                            end
                            else
                            begin
                                rsp_reg.finished <= 1'b0;
                                rsp_reg.running  <= active_reg;
                            end
                        end
                        else
                        begin
                            rsp_reg.current_value <= level_reg;
                            rsp_reg.finished      <= 1'b0;
                            rsp_reg.running       <= active_reg;
                        end
                        rsp_reg.blend_fraction <= shaped_reg;
                        rsp_reg.updated        <= updated_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The block is busy in the cycle after it takes a request.
    `EIT_ASSERT_NEXT(a_busy_after_accept, accept, !req_ready, "request taken while busy")

    // The shaped fraction never exceeds one.
    `EIT_ASSERT_SAME(a_fraction_bound, rsp_valid, rsp.blend_fraction <= FRAC_ONE,
                     "blend fraction above one")

    // A finishing response is an update that leaves the interval idle.
    `EIT_ASSERT_SAME(a_finish_flags, rsp_valid && rsp.finished,
                     rsp.updated && !rsp.running, "inconsistent finish flags")

    // The divider reports completion only while the sequencer waits for it.
    `EIT_ASSERT_SAME(a_div_done_state, div_done, state_reg == S_DIV,
                     "divider done outside its wait state")

endmodule

// File: sv/eit_regs.sv
// ----------------------------------------------------------------------------
// Eased interval tween configuration registers
// APB-style register file holding start, stop, duration and blend mode.
// ----------------------------------------------------------------------------
module eit_regs
    import eit_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       write_en;

    assign index    = reg_index_t'(paddr[ADDR_W-1:2]);
    assign write_en = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (write_en)
        begin
            case (index)
                REG_START_VALUE: cfg_reg.start_value <= pwdata;
                REG_STOP_VALUE:  cfg_reg.stop_value  <= pwdata;
                REG_DURATION:    cfg_reg.duration    <= pwdata;
                REG_BLEND_MODE:  cfg_reg.blend_mode  <= blend_mode_t'(pwdata[1:0]);
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read back the addressed register.
    always_comb
    begin
        case (index)
            REG_START_VALUE: prdata = cfg_reg.start_value;
            REG_STOP_VALUE:  prdata = cfg_reg.stop_value;
            REG_DURATION:    prdata = cfg_reg.duration;
            REG_BLEND_MODE:  prdata = {{(DATA_W-2){1'b0}}, cfg_reg.blend_mode};
            default:         prdata = '0;
        endcase
    end

endmodule

// File: sv/eit_divider.sv
// ----------------------------------------------------------------------------
// Eased interval tween fraction divider
// Restoring divider producing one quotient bit per cycle of (e << F) / d.
// ----------------------------------------------------------------------------
module eit_divider
    import eit_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TIME_W-1:0]    dividend,
    input  logic [TIME_W-1:0]    divisor,
    output logic                 done,
    output logic [FRAC_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_BITS - 1);

    logic                 running_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [FRAC_BITS-1:0] quot_reg;
    logic [TIME_W:0]      shifted;
    logic [TIME_W:0]      trial;
    logic                 fits;

    // One restoring step: the remainder stays below the divisor, so it fits.
    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, divisor};
    assign fits    = shifted >= {1'b0, divisor};

    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
            rem_reg     <= '0;
            quot_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                running_reg <= 1'b1;
                count_reg   <= '0;
                rem_reg     <= dividend;
                quot_reg    <= '0;
            end
            else if (running_reg)
            begin
                rem_reg   <= fits ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
                quot_reg  <= {quot_reg[FRAC_BITS-2:0], fits};
                count_reg <= count_reg + 1'b1;
                if (count_reg == LAST_STEP)
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

endmodule

// File: sv/eit_mul.sv
// ----------------------------------------------------------------------------
// Eased interval tween shared multiplier
// Signed by unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module eit_mul
    import eit_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic        [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] product
);

    logic signed [MUL_B_W:0]  b_ext;
    logic signed [MUL_P_W-1:0] prod_reg;

    assign b_ext   = $signed({1'b0, b});
    assign product = prod_reg;

    // Product register; the sequencer selects the operands in each state.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b_ext;
    end

endmodule
